>>> hw/rtl/rifd_pkg.sv
// Shared constants and the arctangent table of the impedance block.
package rifd_pkg;

	localparam int SAMPLE_BITS_DEF = 18;
	localparam int RES_W           = 20;
	localparam int NP_W            = 16;
	localparam int MAG_W           = 40;
	localparam int PH_W            = 16;
	localparam int Z_W             = 21;
	localparam int CORDIC_STEPS    = 17;
	localparam int STEP_W          = 5;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 32;

	localparam logic [MAG_W-1:0]    MAG_MAX   = {MAG_W{1'b1}};
	localparam logic signed [Z_W-1:0] PI_Q16  = 21'sd205887;
	localparam logic signed [PH_W-1:0] PHASE_LIM = 16'sd25736;

	localparam logic [RES_W-1:0] CAL_RES_RESET = 20'd10000;
	localparam logic [NP_W-1:0]  NUM_PTS_RESET = 16'd100;

	localparam logic [CFG_IDX_W-1:0] CFG_CAL_RES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_PTS = 2'd1;

	// atan(2^-i) in signed Q4.16
	function automatic logic signed [Z_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
		logic signed [Z_W-1:0] t;
		unique case (i)
			5'd0:  t = 21'sd51472;
			5'd1:  t = 21'sd30385;
			5'd2:  t = 21'sd16055;
			5'd3:  t = 21'sd8150;
			5'd4:  t = 21'sd4091;
			5'd5:  t = 21'sd2047;
			5'd6:  t = 21'sd1024;
			5'd7:  t = 21'sd512;
			5'd8:  t = 21'sd256;
			5'd9:  t = 21'sd128;
			5'd10: t = 21'sd64;
			5'd11: t = 21'sd32;
			5'd12: t = 21'sd16;
			5'd13: t = 21'sd8;
			5'd14: t = 21'sd4;
			5'd15: t = 21'sd2;
			5'd16: t = 21'sd1;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

>>> hw/rtl/rifd_cordic.sv
// Iterative vectoring CORDIC: one rotation step per cycle, angle in signed Q4.16.
module rifd_cordic #(
	parameter int SAMPLE_BITS = rifd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [SAMPLE_BITS-1:0]     re,
	input  logic signed [SAMPLE_BITS-1:0]     im,
	output logic                              done,
	output logic signed [rifd_pkg::Z_W-1:0]   angle
);
	localparam int XW = SAMPLE_BITS + 24 + 3;
	localparam logic [rifd_pkg::STEP_W-1:0] LAST_STEP =
		rifd_pkg::STEP_W'(rifd_pkg::CORDIC_STEPS - 1);

	typedef enum logic {C_IDLE, C_RUN} cstate_t;

	cstate_t                        state_q;
	logic [rifd_pkg::STEP_W-1:0]    step_q;
	logic signed [XW-1:0]           x_q, y_q;
	logic signed [rifd_pkg::Z_W-1:0] z_q;
	logic                           done_q;

	logic signed [XW-1:0] xe, ye, xs, ys, x0, y0;
	logic                 zero_vec;

	always_comb begin
		xe = {{(XW-SAMPLE_BITS){re[SAMPLE_BITS-1]}}, re};
		ye = -{{(XW-SAMPLE_BITS){im[SAMPLE_BITS-1]}}, im};
		zero_vec = (re == '0) && (im == '0);
		if (re[SAMPLE_BITS-1]) begin
			x0 = (-xe) <<< 24;
			y0 = (-ye) <<< 24;
		end else begin
			x0 = xe <<< 24;
			y0 = ye <<< 24;
		end
		xs = x_q >>> step_q;
		ys = y_q >>> step_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
			z_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						x_q    <= x0;
						y_q    <= y0;
						step_q <= '0;
						if (zero_vec) begin
							z_q    <= '0;
							done_q <= 1'b1;
						end else begin
							// left half-plane: fold and start at +pi or -pi
							if (re[SAMPLE_BITS-1])
								z_q <= ye[XW-1] ? -rifd_pkg::PI_Q16 : rifd_pkg::PI_Q16;
							else
								z_q <= '0;
							state_q <= C_RUN;
						end
					end
				end
				C_RUN: begin
					if (!y_q[XW-1]) begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + rifd_pkg::atan_q16(step_q);
					end else begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - rifd_pkg::atan_q16(step_q);
					end
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						state_q <= C_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign angle = z_q;

	property p_zero_angle;
		@(posedge clk) disable iff (!arst_n)
			(state_q == C_IDLE && start && zero_vec) |=> (done_q && z_q == '0);
	endproperty
	a_zero_angle: assert property (p_zero_angle) else $error("zero vector angle not zero");

endmodule

>>> hw/rtl/rifd_mag.sv
// Magnitude ratio: shared squarer, shift-add multiply, restoring divide and square root.
module rifd_mag #(
	parameter int SAMPLE_BITS = rifd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [SAMPLE_BITS-1:0]     cal_re,
	input  logic signed [SAMPLE_BITS-1:0]     cal_im,
	input  logic signed [SAMPLE_BITS-1:0]     unk_re,
	input  logic signed [SAMPLE_BITS-1:0]     unk_im,
	input  logic [rifd_pkg::RES_W-1:0]        cal_res,
	output logic                              done,
	output logic [rifd_pkg::MAG_W-1:0]        mag,
	output logic                              zdiv
);
	localparam int P_W   = 2 * SAMPLE_BITS;
	localparam int MUL_W = (SAMPLE_BITS > rifd_pkg::RES_W) ? SAMPLE_BITS : rifd_pkg::RES_W;
	localparam int Q_W   = 2 * rifd_pkg::MAG_W;
	localparam int NUM_W = Q_W + P_W;
	localparam int SR_W  = rifd_pkg::MAG_W + 2;
	localparam int CNT_W = $clog2(Q_W);
	localparam int K_W   = 2 * rifd_pkg::RES_W + 16;
	localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(P_W - 1);
	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(Q_W - 1);
	localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(rifd_pkg::MAG_W - 1);
	localparam logic [2:0] SEL_CR = 3'd0, SEL_CI = 3'd1, SEL_UR = 3'd2,
		SEL_UI = 3'd3, SEL_RES = 3'd4;

	typedef enum logic [2:0] {M_IDLE, M_SQ, M_MUL, M_CHK, M_DIV, M_SQRT} mstate_t;

	mstate_t                      state_q;
	logic [2:0]                   sel_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [P_W-1:0]               pc_q, pu_q, mplier_q, rem_q;
	logic [2*rifd_pkg::RES_W-1:0] r2_q;
	logic [NUM_W-1:0]             acc_q, mcand_q;
	logic [Q_W-1:0]               lo_q;
	logic [SR_W-1:0]              srem_q;
	logic [rifd_pkg::MAG_W-1:0]   root_q, mag_q;
	logic                         zdiv_q, done_q;

	logic signed [SAMPLE_BITS-1:0] sv;
	logic [SAMPLE_BITS:0]          sneg;
	logic [MUL_W-1:0]              op;
	logic [2*MUL_W-1:0]            prod;
	logic [P_W:0]                  dtrial;
	logic                          dge;
	logic [SR_W+1:0]               st, strial;
	logic                          sge;

	always_comb begin
		unique case (sel_q)
			SEL_CR:  sv = cal_re;
			SEL_CI:  sv = cal_im;
			SEL_UR:  sv = unk_re;
			default: sv = unk_im;
		endcase
		sneg = -{sv[SAMPLE_BITS-1], sv};
		if (sel_q == SEL_RES)
			op = MUL_W'(cal_res);
		else if (sv[SAMPLE_BITS-1])
			op = MUL_W'(sneg[SAMPLE_BITS-1:0]);
		else
			op = MUL_W'(sv);
		prod = op * op;

		dtrial = {rem_q, lo_q[Q_W-1]};
		dge    = dtrial >= {1'b0, pu_q};

		st     = {srem_q, lo_q[Q_W-1:Q_W-2]};
		strial = (SR_W+2)'({root_q, 2'b01});
		sge    = st >= strial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
			sel_q   <= '0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (start) begin
						sel_q   <= SEL_CR;
						pc_q    <= '0;
						pu_q    <= '0;
						state_q <= M_SQ;
					end
				end
				M_SQ: begin
					if (sel_q == SEL_CR || sel_q == SEL_CI)
						pc_q <= pc_q + prod[P_W-1:0];
					else if (sel_q == SEL_UR || sel_q == SEL_UI)
						pu_q <= pu_q + prod[P_W-1:0];
					sel_q <= sel_q + 1'b1;
					if (sel_q == SEL_RES) begin
						r2_q     <= prod[2*rifd_pkg::RES_W-1:0];
						mcand_q  <= NUM_W'({prod[2*rifd_pkg::RES_W-1:0], 16'b0});
						mplier_q <= pc_q;
						acc_q    <= '0;
						cnt_q    <= '0;
						state_q  <= M_MUL;
					end
				end
				M_MUL: begin
					if (mplier_q[0])
						acc_q <= acc_q + mcand_q;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q + 1'b1;
					if (cnt_q == MUL_LAST)
						state_q <= M_CHK;
				end
				M_CHK: begin
					zdiv_q <= (pu_q == '0);
					// quotient reaches 2^80 exactly when the top part is not below the divisor
					if (pu_q == '0 || acc_q[NUM_W-1:Q_W] >= pu_q) begin
						mag_q   <= rifd_pkg::MAG_MAX;
						done_q  <= 1'b1;
						state_q <= M_IDLE;
					end else begin
						rem_q   <= acc_q[NUM_W-1:Q_W];
						lo_q    <= acc_q[Q_W-1:0];
						cnt_q   <= '0;
						state_q <= M_DIV;
					end
				end
				M_DIV: begin
					rem_q <= dge ? P_W'(dtrial - {1'b0, pu_q}) : dtrial[P_W-1:0];
					lo_q  <= {lo_q[Q_W-2:0], dge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST) begin
						srem_q  <= '0;
						root_q  <= '0;
						cnt_q   <= '0;
						state_q <= M_SQRT;
					end
				end
				M_SQRT: begin
					srem_q <= sge ? SR_W'(st - strial) : st[SR_W-1:0];
					root_q <= {root_q[rifd_pkg::MAG_W-2:0], sge};
					lo_q   <= lo_q << 2;
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == SQRT_LAST) begin
						mag_q   <= {root_q[rifd_pkg::MAG_W-2:0], sge};
						done_q  <= 1'b1;
						state_q <= M_IDLE;
					end
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign mag  = mag_q;
	assign zdiv = zdiv_q;

	property p_zdiv_sat;
		@(posedge clk) disable iff (!arst_n)
			(state_q == M_CHK && pu_q == '0) |=> (done_q && mag_q == rifd_pkg::MAG_MAX);
	endproperty
	a_zdiv_sat: assert property (p_zdiv_sat) else $error("zero divisor not saturated");

	property p_k_width;
		@(posedge clk) disable iff (!arst_n)
			(state_q == M_MUL) |-> (r2_q[2*rifd_pkg::RES_W-1:0] == mcand_q[K_W-1:16] || cnt_q != '0);
	endproperty
	a_k_width: assert property (p_k_width) else $error("multiplicand not loaded from R squared");

endmodule

>>> hw/rtl/impedance_from_dft_pairs.sv
// Top level: word grouping, point count, sequencing of magnitude and angle units.
//
//  channel | signals                                   | role
//  in      | in_valid, in_stall, fifo_word, first_of_sweep | raw DFT words, one per transaction
//  out     | out_valid, out_stall, impedance_magnitude, phase_radians,
//          | point_number, last_point, zero_divisor    | one result per four words
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register writes, always ready
//
// Words one to three of a group are taken without a stall. The fourth starts the magnitude
// unit, which runs squarer, shift-add multiply, range check, restoring divide and square root
// in that order, and stops after the range check on a zero divisor or an oversized quotient.
// The two angles run meanwhile, one after the other, on one CORDIC. The result is loaded once
// both units are done. in_stall stays high from the fourth word until the result is loaded
// into the output register, which needs that register free. Reset is asynchronous.
module impedance_from_dft_pairs #(
	parameter int SAMPLE_BITS = rifd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [31:0]                           fifo_word,
	input  logic                                  first_of_sweep,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [rifd_pkg::MAG_W-1:0]            impedance_magnitude,
	output logic signed [rifd_pkg::PH_W-1:0]      phase_radians,
	output logic [rifd_pkg::NP_W-1:0]             point_number,
	output logic                                  last_point,
	output logic                                  zero_divisor,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [rifd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rifd_pkg::CFG_DATA_W-1:0]       cfg_data
);
	localparam logic [1:0] POS_CR = 2'd0, POS_CI = 2'd1, POS_UR = 2'd2, POS_UI = 2'd3;

	typedef enum logic [2:0] {T_IDLE, T_KICK, T_ANG_CAL, T_ANG_UNK, T_WAIT} tstate_t;

	tstate_t                         state_q;
	logic [1:0]                      pos_q;
	logic signed [SAMPLE_BITS-1:0]   cal_re_q, cal_im_q, unk_re_q, unk_im_q;
	logic [rifd_pkg::NP_W-1:0]       pcnt_q, pnum_q, npts_q;
	logic [rifd_pkg::RES_W-1:0]      cal_res_q;
	logic signed [rifd_pkg::Z_W-1:0] ang_cal_q, ang_unk_q;
	logic                            mag_ok_q;
	logic                            out_valid_q, last_q, zdiv_q;
	logic [rifd_pkg::MAG_W-1:0]      mag_q;
	logic signed [rifd_pkg::PH_W-1:0] ph_q;
	logic [rifd_pkg::NP_W-1:0]       onum_q;

	logic                            accept, load;
	logic [1:0]                      pos_eff;
	logic [rifd_pkg::NP_W-1:0]       cnt_eff;
	logic signed [SAMPLE_BITS-1:0]   sample;
	logic                            cor_start, cor_done, mag_done, mag_zdiv;
	logic signed [SAMPLE_BITS-1:0]   cor_re, cor_im;
	logic signed [rifd_pkg::Z_W-1:0] cor_angle;
	logic [rifd_pkg::MAG_W-1:0]      mag_val;
	logic signed [rifd_pkg::Z_W:0]   dphi, dround;
	logic signed [rifd_pkg::Z_W-4:0] ph_wide;
	logic signed [rifd_pkg::PH_W-1:0] ph_c;

	assign in_stall  = (state_q != T_IDLE);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign pos_eff   = first_of_sweep ? POS_CR : pos_q;
	assign cnt_eff   = first_of_sweep ? '0 : pcnt_q;
	assign sample    = fifo_word[SAMPLE_BITS-1:0];
	assign load      = (state_q == T_WAIT) && mag_ok_q && (!out_valid_q || !out_stall);

	assign cor_start = (state_q == T_KICK) || (state_q == T_ANG_CAL && cor_done);
	assign cor_re    = (state_q == T_ANG_CAL) ? unk_re_q : cal_re_q;
	assign cor_im    = (state_q == T_ANG_CAL) ? unk_im_q : cal_im_q;

	always_comb begin
		dphi    = {ang_cal_q[rifd_pkg::Z_W-1], ang_cal_q} - {ang_unk_q[rifd_pkg::Z_W-1], ang_unk_q};
		dround  = dphi + (rifd_pkg::Z_W+1)'(8);
		ph_wide = dround[rifd_pkg::Z_W:4];
		if (ph_wide > (rifd_pkg::Z_W-3)'(rifd_pkg::PHASE_LIM))
			ph_c = rifd_pkg::PHASE_LIM;
		else if (ph_wide < -(rifd_pkg::Z_W-3)'(rifd_pkg::PHASE_LIM))
			ph_c = -rifd_pkg::PHASE_LIM;
		else
			ph_c = ph_wide[rifd_pkg::PH_W-1:0];
	end

	rifd_mag #(.SAMPLE_BITS(SAMPLE_BITS)) u_mag (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == T_KICK),
		.cal_re  (cal_re_q),
		.cal_im  (cal_im_q),
		.unk_re  (unk_re_q),
		.unk_im  (unk_im_q),
		.cal_res (cal_res_q),
		.done    (mag_done),
		.mag     (mag_val),
		.zdiv    (mag_zdiv)
	);

	rifd_cordic #(.SAMPLE_BITS(SAMPLE_BITS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.re     (cor_re),
		.im     (cor_im),
		.done   (cor_done),
		.angle  (cor_angle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			pos_q       <= POS_CR;
			pcnt_q      <= '0;
			cal_re_q    <= '0;
			cal_im_q    <= '0;
			unk_re_q    <= '0;
			unk_im_q    <= '0;
			cal_res_q   <= rifd_pkg::CAL_RES_RESET;
			npts_q      <= rifd_pkg::NUM_PTS_RESET;
			mag_ok_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == rifd_pkg::CFG_CAL_RES)
					cal_res_q <= cfg_data[rifd_pkg::RES_W-1:0];
				else if (cfg_index == rifd_pkg::CFG_NUM_PTS)
					npts_q <= cfg_data[rifd_pkg::NP_W-1:0];
			end
			if (mag_done)
				mag_ok_q <= 1'b1;
			if (out_valid_q && !out_stall && !load)
				out_valid_q <= 1'b0;
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						pcnt_q <= cnt_eff;
						unique case (pos_eff)
							POS_CR: begin cal_re_q <= sample; pos_q <= POS_CI; end
							POS_CI: begin cal_im_q <= sample; pos_q <= POS_UR; end
							POS_UR: begin unk_re_q <= sample; pos_q <= POS_UI; end
							default: begin
								unk_im_q <= sample;
								pos_q    <= POS_CR;
								pnum_q   <= cnt_eff + 1'b1;
								pcnt_q   <= cnt_eff + 1'b1;
								state_q  <= T_KICK;
							end
						endcase
					end
				end
				T_KICK: begin
					mag_ok_q <= 1'b0;
					state_q  <= T_ANG_CAL;
				end
				T_ANG_CAL: begin
					if (cor_done) begin
						ang_cal_q <= cor_angle;
						state_q   <= T_ANG_UNK;
					end
				end
				T_ANG_UNK: begin
					if (cor_done) begin
						ang_unk_q <= cor_angle;
						state_q   <= T_WAIT;
					end
				end
				T_WAIT: begin
					if (load) begin
						mag_q       <= mag_val;
						zdiv_q      <= mag_zdiv;
						ph_q        <= ph_c;
						onum_q      <= pnum_q;
						last_q      <= (pnum_q == npts_q);
						out_valid_q <= 1'b1;
						state_q     <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign out_valid           = out_valid_q;
	assign impedance_magnitude = mag_q;
	assign phase_radians       = ph_q;
	assign point_number        = onum_q;
	assign last_point          = last_q;
	assign zero_divisor        = zdiv_q;

	property p_group_stalls;
		@(posedge clk) disable iff (!arst_n)
			(accept && pos_eff == POS_UI) |=> in_stall;
	endproperty
	a_group_stalls: assert property (p_group_stalls) else $error("fourth word did not start work");

	property p_zdiv_mag;
		@(posedge clk) disable iff (!arst_n)
			(out_valid_q && zdiv_q) |-> (mag_q == rifd_pkg::MAG_MAX);
	endproperty
	a_zdiv_mag: assert property (p_zdiv_mag) else $error("zero divisor without saturation");

	property p_phase_lim;
		@(posedge clk) disable iff (!arst_n)
			out_valid_q |-> (ph_q <= rifd_pkg::PHASE_LIM && ph_q >= -rifd_pkg::PHASE_LIM);
	endproperty
	a_phase_lim: assert property (p_phase_lim) else $error("phase beyond clamp");

	property p_last_flag;
		@(posedge clk) disable iff (!arst_n)
			load |=> (last_q == (onum_q == npts_q));
	endproperty
	a_last_flag: assert property (p_last_flag) else $error("last flag mismatch");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the DFT-pair impedance block.
`timescale 1ns / 1ps

module testbench;

	localparam int SB = rifd_pkg::SAMPLE_BITS_DEF;
	localparam int STALL_LIMIT = 20000;
	localparam int LONG_HOLD = 2500;
	localparam int DRAIN_WAIT = 200;

	typedef struct packed {
		logic [rifd_pkg::MAG_W-1:0] mag;
		logic signed [rifd_pkg::PH_W-1:0] ph;
		logic [rifd_pkg::NP_W-1:0] pnum;
		logic last;
		logic zdiv;
	} impedance_t;

	localparam longint ATAN_TAB [rifd_pkg::CORDIC_STEPS] = '{
		51472, 30385, 16055, 8150, 4091, 2047, 1024, 512, 256,
		128, 64, 32, 16, 8, 4, 2, 1
	};

	class impedance_scoreboard;
		impedance_t expq[$];
		int errors = 0;
		logic [rifd_pkg::RES_W-1:0] cal_res = rifd_pkg::CAL_RES_RESET;
		logic [rifd_pkg::NP_W-1:0] num_pts = rifd_pkg::NUM_PTS_RESET;
		logic [1:0] word_pos = 0;
		longint cre = 0, cim = 0, ure = 0;
		logic [rifd_pkg::NP_W-1:0] pt_count = 0;

		function void set_reg(logic [rifd_pkg::CFG_IDX_W-1:0] idx,
			logic [rifd_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				rifd_pkg::CFG_CAL_RES: cal_res = val[rifd_pkg::RES_W-1:0];
				rifd_pkg::CFG_NUM_PTS: num_pts = val[rifd_pkg::NP_W-1:0];
				default: ;
			endcase
		endfunction

		function longint unsigned sq(longint v);
			longint unsigned a;
			a = v < 0 ? -v : v;
			return a * a;
		endfunction

		function longint vec_angle(longint re, longint im);
			longint x, y, z, xs, ys;
			x = re;
			y = -im;
			z = 0;
			if (x == 0 && y == 0)
				return 0;
			if (x < 0) begin
				z = (y >= 0) ? longint'(rifd_pkg::PI_Q16) : -longint'(rifd_pkg::PI_Q16);
				x = -x;
				y = -y;
			end
			x = x <<< 24;
			y = y <<< 24;
			for (int i = 0; i < rifd_pkg::CORDIC_STEPS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys; y = y - xs; z = z + ATAN_TAB[i];
				end else begin
					x = x - ys; y = y + xs; z = z - ATAN_TAB[i];
				end
			end
			return z;
		endfunction

		// take one accepted word; queue a result when it closes a group
		function void note_word(logic [31:0] w, logic first);
			longint v, d, ph;
			longint unsigned pc, pu, k, r, t;
			logic [127:0] q;
			impedance_t e;
			if (first) begin
				word_pos = 0;
				pt_count = 0;
			end
			v = longint'($signed(w[SB-1:0]));
			case (word_pos)
				2'd0: begin cre = v; word_pos = 1; return; end
				2'd1: begin cim = v; word_pos = 2; return; end
				2'd2: begin ure = v; word_pos = 3; return; end
				default: word_pos = 0;
			endcase
			pc = sq(cre) + sq(cim);
			pu = sq(ure) + sq(v);
			e.zdiv = (pu == 0);
			if (e.zdiv) begin
				e.mag = rifd_pkg::MAG_MAX;
			end else begin
				k = (longint'(cal_res) * longint'(cal_res)) << 16;
				q = (128'(k) * 128'(pc)) / 128'(pu);
				if ((q >> 80) != 0) begin
					e.mag = rifd_pkg::MAG_MAX;
				end else begin
					r = 0;
					for (int b = 39; b >= 0; b--) begin
						t = r | (64'd1 << b);
						if (128'(t) * 128'(t) <= q)
							r = t;
					end
					e.mag = r[rifd_pkg::MAG_W-1:0];
				end
			end
			d = vec_angle(cre, cim) - vec_angle(ure, v);
			ph = (d + 8) >>> 4;
			if (ph > longint'(rifd_pkg::PHASE_LIM)) ph = rifd_pkg::PHASE_LIM;
			if (ph < -longint'(rifd_pkg::PHASE_LIM)) ph = -longint'(rifd_pkg::PHASE_LIM);
			e.ph = ph[rifd_pkg::PH_W-1:0];
			pt_count = pt_count + 1'b1;
			e.pnum = pt_count;
			e.last = (pt_count == num_pts);
			expq.push_back(e);
		endfunction

		function void check_result(impedance_t a);
			impedance_t e;
			if (expq.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: mag=%0d ph=%0d pt=%0d", a.mag, a.ph, a.pnum);
				return;
			end
			e = expq.pop_front();
			if (a !== e) begin
				errors++;
				if (errors <= 10)
					$display({"result differs: exp mag=%0d ph=%0d pt=%0d last=%0b zd=%0b",
						" / got mag=%0d ph=%0d pt=%0d last=%0b zd=%0b"},
						e.mag, e.ph, e.pnum, e.last, e.zdiv,
						a.mag, a.ph, a.pnum, a.last, a.zdiv);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [31:0] fifo_word = 0;
	logic first_of_sweep = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [rifd_pkg::MAG_W-1:0] impedance_magnitude;
	logic signed [rifd_pkg::PH_W-1:0] phase_radians;
	logic [rifd_pkg::NP_W-1:0] point_number;
	logic last_point;
	logic zero_divisor;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [rifd_pkg::CFG_IDX_W-1:0] cfg_index = rifd_pkg::CFG_CAL_RES;
	logic [rifd_pkg::CFG_DATA_W-1:0] cfg_data = 0;

	impedance_scoreboard sb = new();
	bit quiet = 0;
	bit hold_req = 0;
	bit hold_done = 0;
	int hold_left = 0;
	int burst_left = 0;
	int idle_cycles = 0;

	impedance_from_dft_pairs dut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// receiver: check results, stall in bursts, one long hold-off on request
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{impedance_magnitude, phase_radians, point_number,
				last_point, zero_divisor});
		if (hold_req && !hold_done) begin
			if (hold_left == 0)
				hold_left = LONG_HOLD;
			hold_left--;
			if (hold_left == 0)
				hold_done = 1;
			out_stall <= 1;
		end else if (burst_left > 0) begin
			burst_left--;
			out_stall <= 1;
		end else if (!quiet && $urandom_range(0, 11) == 0) begin
			burst_left = $urandom_range(1, 17) - 1;
			out_stall <= 1;
		end else begin
			out_stall <= 0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("impedance_from_dft_pairs: mismatch");
			$finish;
		end
	end

	task automatic send_word(logic [31:0] w, logic first);
		in_valid <= 1;
		fifo_word <= w;
		first_of_sweep <= first;
		do @(posedge clk); while (in_stall);
		sb.note_word(w, first);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [rifd_pkg::CFG_IDX_W-1:0] idx,
		logic [rifd_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.expq.size() > 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic logic [31:0] pack(int v, bit junk);
		logic [31:0] w;
		w = junk ? $urandom : 32'd0;
		w[SB-1:0] = v[SB-1:0];
		return w;
	endfunction

	function automatic int rand_comp();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return $signed($urandom_range(0, 8)) - 4;
			2: return $urandom_range(0, 1) ? 131071 : -131072;
			3: return $signed($urandom_range(0, 2000)) - 1000;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_group(int a, int b, int c, int d, bit first, bit junk);
		send_word(pack(a, junk), first);
		send_word(pack(b, junk), 0);
		send_word(pack(c, junk), 0);
		send_word(pack(d, junk), 0);
	endtask

	task automatic random_words(int n);
		int sent;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 15) == 0) begin
				// broken group: restart mid-way
				repeat ($urandom_range(1, 3)) begin
					send_word($urandom, $urandom_range(0, 5) == 0);
					sent++;
				end
			end else begin
				send_group(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
					$urandom_range(0, 19) == 0, $urandom_range(0, 1));
				sent += 4;
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// defaults straight out of reset
		random_words(120);
		drain();

		write_reg(rifd_pkg::CFG_CAL_RES, 1000000);
		write_reg(rifd_pkg::CFG_NUM_PTS, 4);
		send_group(131071, 131071, 1, 0, 1, 0);          // oversized magnitude
		send_group(-131072, -131072, -131072, 0, 0, 0);  // most negative inputs
		send_group(-100, -50, -100, 50, 0, 1);           // negative real, both pi sides
		send_group(0, 0, 3, 4, 0, 0);                    // zero calibration vector
		send_group(5, 5, 0, 0, 0, 1);                    // zero divisor
		send_word(pack(7, 1), 0);
		send_word(pack(9, 1), 0);
		send_group(1, -1, -1, 1, 1, 1);                  // restart mid-group
		drain();

		write_reg(rifd_pkg::CFG_CAL_RES, 1);
		write_reg(rifd_pkg::CFG_NUM_PTS, 1);
		random_words(160);
		drain();

		write_reg(rifd_pkg::CFG_CAL_RES, 0);             // zero resistor
		write_reg(rifd_pkg::CFG_NUM_PTS, 65535);
		hold_req = 1;
		random_words(160);
		drain();

		write_reg(rifd_pkg::CFG_CAL_RES, 32'hFFFF_FFFF);
		write_reg(rifd_pkg::CFG_NUM_PTS, 0);
		random_words(160);
		drain();

		write_reg(rifd_pkg::CFG_CAL_RES, $urandom_range(1, 1000000));
		write_reg(rifd_pkg::CFG_NUM_PTS, $urandom_range(1, 60));
		random_words(160);
		drain();

		quiet = 1;
		write_reg(rifd_pkg::CFG_CAL_RES, 10000);
		write_reg(rifd_pkg::CFG_NUM_PTS, $urandom_range(1, 40));
		random_words(120);
		drain();

		if (sb.errors == 0)
			$display("impedance_from_dft_pairs: match");
		else
			$display("impedance_from_dft_pairs: mismatch");
		$finish;
	end

endmodule
